// ----- src/rle16_pkg.sv -----
// shared types and constants for the 16-bit run-length word decoder
`default_nettype none

package rle16_pkg;

   localparam int WORD_W  = 16;
   localparam int INDEX_W = 14;
   localparam int COUNT_W = 15;
   localparam int LEN_W   = 32;

   // input beat
   typedef struct packed {
      logic [WORD_W-1:0] packed_word;
      logic              first_word;
   } req_type;

   // result beat
   typedef struct packed {
      logic [INDEX_W-1:0] write_index;
      logic [WORD_W-1:0]  word_value;
      logic [COUNT_W-1:0] run_count;
      logic               final_res;
   } rsp_type;

   // command kinds passed from the parser to the run writer
   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_CHECK   = 2'd1,
      CMD_RUN     = 2'd2
   } cmd_kind_type;

   // one queued command
   typedef struct packed {
      cmd_kind_type       kind;
      logic [WORD_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      logic               len_done;
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/rle16_parser.sv -----
// front end: parses the length, block headers and value words into commands
`default_nettype none

module rle16_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rle16_pkg::req_type req_data,
   output logic                   push_valid,
   output rle16_pkg::cmd_type     push_cmd,
   input  wire logic              queue_full
);
   import rle16_pkg::*;

   typedef enum logic [2:0] {
      PH_LEN_LO,
      PH_LEN_HI,
      PH_HEADER,
      PH_REPEAT,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [LEN_W-1:0]   plen_ff, plen_in, plen_cur;
   logic [LEN_W-1:0]   bytes_ff, bytes_in, bytes_cur, bytes_inc;
   logic [COUNT_W-1:0] rem_ff, rem_in, rem_cur;
   logic [LEN_W-1:0]   full_len;
   logic               accept;
   logic               reached;
   logic [WORD_W-1:0]  word;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign word      = req_data.packed_word;

   // a first-word marker restarts from clean state
   always_comb begin
      phase_cur = req_data.first_word ? PH_LEN_LO : phase_ff;
      plen_cur  = req_data.first_word ? '0 : plen_ff;
      bytes_cur = req_data.first_word ? '0 : bytes_ff;
      rem_cur   = req_data.first_word ? '0 : rem_ff;
   end

   // saturating byte count for a header or value word
   always_comb begin
      if (bytes_cur > 32'hFFFF_FFFD) begin
         bytes_inc = 32'hFFFF_FFFF;
      end else begin
         bytes_inc = bytes_cur + 32'd2;
      end
      reached  = bytes_inc >= plen_cur;
      full_len = {word, plen_cur[WORD_W-1:0]};
   end

   // phase decode and command generation
   always_comb begin
      phase_in         = phase_ff;
      plen_in          = plen_ff;
      bytes_in         = bytes_ff;
      rem_in           = rem_ff;
      push_valid       = 1'b0;
      push_cmd.kind    = CMD_CHECK;
      push_cmd.value   = word;
      push_cmd.count   = rem_cur;
      push_cmd.len_done = 1'b0;
      if (accept) begin
         phase_in = phase_cur;
         plen_in  = plen_cur;
         bytes_in = bytes_cur;
         rem_in   = rem_cur;
         if (req_data.first_word) begin
            push_valid    = 1'b1;
            push_cmd.kind = CMD_RESTART;
         end
         unique case (phase_cur)
            PH_LEN_LO: begin
               plen_in  = {{(LEN_W-WORD_W){1'b0}}, word};
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               plen_in = full_len;
               if (bytes_cur >= full_len) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in      = PH_HEADER;
                  push_valid    = 1'b1;
                  push_cmd.kind = CMD_CHECK;
               end
            end
            PH_HEADER: begin
               bytes_in = bytes_inc;
               if (word == '0) begin
                  if (reached) begin
                     phase_in = PH_DONE;
                  end else begin
                     push_valid    = 1'b1;
                     push_cmd.kind = CMD_CHECK;
                  end
               end else if (!word[WORD_W-1]) begin
                  rem_in   = word[COUNT_W-1:0];
                  phase_in = PH_REPEAT;
               end else begin
                  // literal count minus one is the bitwise inverse
                  rem_in   = ~word[COUNT_W-1:0];
                  phase_in = PH_LITERAL;
               end
            end
            PH_REPEAT: begin
               bytes_in          = bytes_inc;
               push_valid        = 1'b1;
               push_cmd.kind     = CMD_RUN;
               push_cmd.count    = rem_cur;
               push_cmd.len_done = reached;
               phase_in          = reached ? PH_DONE : PH_HEADER;
            end
            PH_LITERAL: begin
               bytes_in       = bytes_inc;
               push_valid     = 1'b1;
               push_cmd.kind  = CMD_RUN;
               push_cmd.count = COUNT_W'(1);
               if (rem_cur == '0) begin
                  push_cmd.len_done = reached;
                  phase_in          = reached ? PH_DONE : PH_HEADER;
               end else begin
                  rem_in = rem_cur - COUNT_W'(1);
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN_LO;
         plen_ff  <= '0;
         bytes_ff <= '0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         plen_ff  <= plen_in;
         bytes_ff <= bytes_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/rle16_cmd_queue.sv -----
// small command queue between the parser and the run writer
`default_nettype none

module rle16_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire rle16_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   not_empty,
   output rle16_pkg::cmd_type     head_cmd,
   input  wire logic              pop
);
   import rle16_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full      = cnt_ff == CW'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head_cmd  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- src/rle16_run_writer.sv -----
// back end: clips runs at the output limit and drives the result register
`default_nettype none

module rle16_run_writer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [rle16_pkg::COUNT_W-1:0]    limit,
   input  wire logic                             cmd_valid,
   input  wire rle16_pkg::cmd_type               cmd,
   output logic                                  cmd_pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output rle16_pkg::rsp_type                    rsp_data
);
   import rle16_pkg::*;

   logic [COUNT_W-1:0] written_ff, written_in;
   logic               stop_ff, stop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               advance;
   logic [COUNT_W-1:0] avail, n, written_sum;
   logic               emit;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign cmd_pop   = cmd_valid && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // room left and clipped run length
   always_comb begin
      avail       = (written_ff < limit) ? limit - written_ff : '0;
      n           = (cmd.count < avail) ? cmd.count : avail;
      written_sum = written_ff + n;
   end

   // command execution
   always_comb begin
      written_in          = written_ff;
      stop_in             = stop_ff;
      emit                = 1'b0;
      rsp_in              = rsp_ff;
      if (cmd_pop) begin
         unique case (cmd.kind)
            CMD_RESTART: begin
               written_in = '0;
               stop_in    = 1'b0;
            end
            CMD_CHECK: begin
               if (!stop_ff && written_ff >= limit) begin
                  stop_in = 1'b1;
               end
            end
            CMD_RUN: begin
               if (!stop_ff) begin
                  if (n == '0) begin
                     stop_in = 1'b1;
                  end else begin
                     emit                = 1'b1;
                     written_in          = written_sum;
                     rsp_in.write_index  = written_ff[INDEX_W-1:0];
                     rsp_in.word_value   = cmd.value;
                     rsp_in.run_count    = n;
                     rsp_in.final_res    = (written_sum >= limit) || cmd.len_done;
                     stop_in             = (written_sum >= limit) || cmd.len_done;
                  end
               end
            end
            default: begin
               stop_in = stop_ff;
            end
         endcase
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- src/rle16_word_decoder.sv -----
// top level of the 16-bit run-length word decoder
// Usage:
//  - req channel: one packed 16-bit word per beat; first_word marks the
//    first word of a blob (length low half) and restarts parsing.
//  - rsp channel: one write-run command (index, value, count, final flag)
//    per value word that still fits the destination.
//  - csr channel: writes the destination limit in words; always ready.
//    Write it only while no words are in flight.
// A value word's command is written into the command queue when the word
// is accepted, then into the run writer's result register when the writer
// pops it from the queue.
// Throughput: one word per cycle while the queue is not full; the parser
// takes a word and the run writer retires a queued command each cycle.
// Reset clears the parser to expect a length low half, empties the queue,
// and sets the limit to the smaller of 16384 and OUT_WORDS.
// When the receiver stalls, the result register holds; the queue of
// QUEUE_DEPTH commands keeps accepting words until it fills, then req_ready
// drops.
`default_nettype none

module rle16_word_decoder #(
   parameter int OUT_WORDS   = 16384,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire rle16_pkg::req_type            req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output rle16_pkg::rsp_type                 rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rle16_pkg::COUNT_W-1:0] csr_data
);
   import rle16_pkg::*;

   localparam int COUNT_MAX = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] LIMIT_CAP =
      (OUT_WORDS > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(OUT_WORDS);
   localparam logic [COUNT_W-1:0] LIMIT_RESET =
      (OUT_WORDS > 16384) ? COUNT_W'(16384) : COUNT_W'(OUT_WORDS);

   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic               push_valid;
   cmd_type            push_cmd;
   logic               queue_full;
   logic               queue_not_empty;
   cmd_type            head_cmd;
   logic               cmd_pop;

   assign csr_ready = 1'b1;

   // effective limit, capped by the destination size
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = (csr_data > LIMIT_CAP) ? LIMIT_CAP : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // front end
   rle16_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   // command queue
   rle16_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_cmd   (head_cmd),
      .pop        (cmd_pop)
   );

   // back end
   rle16_run_writer u_writer (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .cmd_valid (queue_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a run is never empty and never exceeds the limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.run_count != '0) && (rsp_data.run_count <= limit_ff))
      else $error("run count out of range");

   // a run never reaches past the limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_data.write_index} + {1'b0, rsp_data.run_count})
                    <= {1'b0, limit_ff})
      else $error("run ends past the output limit");

   // no result directly after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");
`endif

endmodule

`default_nettype wire
